// ----- src/calu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_pkg
// Shared types and constants for the 8-bit ALU with flag register.
// ----------------------------------------------------------------------------
package calu_pkg;

   // Operation codes
   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_ADC   = 4'd1,
      OP_SUB   = 4'd2,
      OP_SBC   = 4'd3,
      OP_AND   = 4'd4,
      OP_XOR   = 4'd5,
      OP_OR    = 4'd6,
      OP_CP    = 4'd7,
      OP_INC   = 4'd8,
      OP_DEC   = 4'd9,
      OP_ADD16 = 4'd10
   } opcode_type;

   localparam int unsigned OPCODE_W = 4;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned BYTE_W   = 8;

   // Flag register layout: z in bit 3 down to c in bit 0
   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   localparam int unsigned FLAGS_W = $bits(flags_type);

   localparam logic [3:0]  NIBBLE_ALL_ONES = 4'hF;
   localparam logic [3:0]  NIBBLE_ZERO     = 4'h0;
   localparam logic [7:0]  BYTE_ZERO       = 8'h00;

   // Stream payload widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 24;

endpackage

// ----- src/calu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_core
// Combinational ALU datapath: result and next flags from opcode, operands
// and the current flag register.
// ----------------------------------------------------------------------------
module calu_core
   import calu_pkg::*;
(
   input  logic [OPCODE_W-1:0] opcode,
   input  logic [WORD_W-1:0]   operand_a,
   input  logic [WORD_W-1:0]   operand_b,
   input  flags_type           flags_cur,
   output logic [WORD_W-1:0]   result,
   output flags_type           flags_next
);

   logic [7:0]  a8;
   logic [7:0]  b8;
   logic        cin_add;
   logic        cin_sub;
   logic [8:0]  add_sum;
   logic [4:0]  add_nib;
   logic [8:0]  sub_diff;
   logic [4:0]  sub_nib;
   logic [7:0]  inc_val;
   logic [7:0]  dec_val;
   logic [16:0] w_sum;
   logic [12:0] w_low;
   logic [7:0]  and_val;
   logic [7:0]  xor_val;
   logic [7:0]  or_val;

   assign a8 = operand_a[7:0];
   assign b8 = operand_b[7:0];

   // Carry-in only for the with-carry forms
   assign cin_add = (opcode_type'(opcode) == OP_ADC) ? flags_cur.c : 1'b0;
   assign cin_sub = (opcode_type'(opcode) == OP_SBC) ? flags_cur.c : 1'b0;

   // Adders and subtractors; top bit is carry or borrow
   assign add_sum  = {1'b0, a8} + {1'b0, b8} + {8'd0, cin_add};
   assign add_nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin_add};
   assign sub_diff = {1'b0, a8} - {1'b0, b8} - {8'd0, cin_sub};
   assign sub_nib  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin_sub};
   assign inc_val  = a8 + 8'd1;
   assign dec_val  = a8 - 8'd1;
   assign w_sum    = {1'b0, operand_a} + {1'b0, operand_b};
   assign w_low    = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
   assign and_val  = a8 & b8;
   assign xor_val  = a8 ^ b8;
   assign or_val   = a8 | b8;

   // Result and flag select
   always_comb begin
      result     = '0;
      flags_next = flags_cur;
      unique case (opcode_type'(opcode))
         OP_ADD, OP_ADC: begin
            result     = {8'd0, add_sum[7:0]};
            flags_next = '{z: (add_sum[7:0] == BYTE_ZERO), n: 1'b0,
                           h: add_nib[4], c: add_sum[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            result     = (opcode_type'(opcode) == OP_CP) ? {8'd0, a8}
                                                         : {8'd0, sub_diff[7:0]};
            flags_next = '{z: (sub_diff[7:0] == BYTE_ZERO), n: 1'b1,
                           h: sub_nib[4], c: sub_diff[8]};
         end
         OP_AND: begin
            result     = {8'd0, and_val};
            flags_next = '{z: (and_val == BYTE_ZERO), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         OP_XOR: begin
            result     = {8'd0, xor_val};
            flags_next = '{z: (xor_val == BYTE_ZERO), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_OR: begin
            result     = {8'd0, or_val};
            flags_next = '{z: (or_val == BYTE_ZERO), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_INC: begin
            result     = {8'd0, inc_val};
            flags_next = '{z: (inc_val == BYTE_ZERO), n: 1'b0,
                           h: (a8[3:0] == NIBBLE_ALL_ONES), c: flags_cur.c};
         end
         OP_DEC: begin
            result     = {8'd0, dec_val};
            flags_next = '{z: (dec_val == BYTE_ZERO), n: 1'b1,
                           h: (a8[3:0] == NIBBLE_ZERO), c: flags_cur.c};
         end
         OP_ADD16: begin
            result     = w_sum[15:0];
            flags_next = '{z: flags_cur.z, n: 1'b0, h: w_low[12], c: w_sum[16]};
         end
         default: begin
            // unused opcodes: zero result, flags held
            result     = '0;
            flags_next = flags_cur;
         end
      endcase
   end

endmodule

// ----- src/cpu_alu_with_flags_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_unit
// 8-bit ALU with zero/subtract/half-carry/carry flag register on stream ports.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while rsp_tready is high; one input register,
// one ALU pass, one result register, flag register updated as each result is registered.
// rsp_tvalid is driven by the result register.
// Reset: synchronous, clears the valid bits of both stages and the flags.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_unit
   import calu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // opcode[3:0], operand_a[19:4], operand_b[35:20]
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // result[15:0], flags_out[19:16]
);

   logic                in_valid_ff, in_valid_in;
   logic [OPCODE_W-1:0] in_op_ff,    in_op_in;
   logic [WORD_W-1:0]   in_a_ff,     in_a_in;
   logic [WORD_W-1:0]   in_b_ff,     in_b_in;
   logic                out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]   out_result_ff, out_result_in;
   flags_type           out_flags_ff,  out_flags_in;
   flags_type           flag_ff,       flag_in;

   logic                req_take;
   logic                out_load;
   logic [WORD_W-1:0]   alu_result;
   flags_type           alu_flags;

   // Stage handshakes
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;

   calu_core u_core (
      .opcode     (in_op_ff),
      .operand_a  (in_a_ff),
      .operand_b  (in_b_ff),
      .flags_cur  (flag_ff),
      .result     (alu_result),
      .flags_next (alu_flags)
   );

   // Next values
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_op_in      = in_op_ff;
      in_a_in       = in_a_ff;
      in_b_in       = in_b_ff;
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      out_flags_in  = out_flags_ff;
      flag_in       = flag_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_result_in = alu_result;
         out_flags_in  = alu_flags;
         flag_in       = alu_flags;
         in_valid_in   = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_op_in    = req_tdata[3:0];
         in_a_in     = req_tdata[19:4];
         in_b_in     = req_tdata[35:20];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flag_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flag_ff      <= flag_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_op_ff      <= in_op_in;
      in_a_ff       <= in_a_in;
      in_b_ff       <= in_b_in;
      out_result_ff <= out_result_in;
      out_flags_ff  <= out_flags_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_flags_ff, out_result_ff};

endmodule

// ----- tb/sv/cpu_alu_with_flags_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_unit_test
// Self-checking bench for the 8-bit ALU with Z/N/H/C flag register. A short
// table of directed operations comes first, then random operations. Every
// accepted request is run through a local flag-register model, and each
// result transaction is compared field by field with the oldest expected value.
// Both stream sides idle in random bursts; the result side also holds off
// once for a long stretch so that the block backs up into the request side.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_unit_test;
   import calu_pkg::*;

   // opcodes outside the defined set, which leave the flags alone
   localparam logic [3:0] OP_RSVD_LO = 4'd11;
   localparam logic [3:0] OP_RSVD_HI = 4'd15;

   localparam int RAND_ITEMS     = 750;
   localparam int TAIL_ITEMS     = 150;   // last items run without idling
   localparam int HOLD_AT        = 100;   // random item that starts the long hold-off
   localparam int PAUSE_AT       = 400;   // random item before which the sender drains
   localparam int LONG_HOLD      = 60;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [WORD_W-1:0] result;
      flags_type         flags;
   } alu_out_type;

   typedef struct {
      logic [3:0]        op;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      bit                typed;     // expected value given in the row
      alu_out_type       exp;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // opcode[3:0], operand_a[19:4], operand_b[35:20]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // result[15:0], flags_out[19:16]

   alu_out_type pending_results[$];
   flags_type   flags_shadow;
   dir_row_type dir_rows[$];
   int          mismatch_count;
   int          idle_cycles;
   int          rx_hold_left;
   bit          long_hold_req;
   bit          quiet_tail;

   cpu_alu_with_flags_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Flag-register ALU: result and new flags for one operation
   function automatic alu_out_type alu_eval(input logic [3:0] op, input logic [WORD_W-1:0] a16,
                                            input logic [WORD_W-1:0] b16,
                                            input flags_type f_in);
      alu_out_type o;
      logic [7:0]  a;
      logic [7:0]  b;
      logic        cin;
      logic [8:0]  sum9;
      logic [4:0]  nib5;
      logic [7:0]  diff;
      logic [12:0] sum13;
      logic [16:0] sum17;
      a        = a16[7:0];
      b        = b16[7:0];
      o.result = '0;
      o.flags  = f_in;
      case (op)
         OP_ADD, OP_ADC: begin
            cin      = (op == OP_ADC) ? f_in.c : 1'b0;
            sum9     = {1'b0, a} + {1'b0, b} + {8'b0, cin};
            nib5     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
            o.result = {8'h00, sum9[7:0]};
            o.flags  = '{z: (sum9[7:0] == 8'h00), n: 1'b0, h: nib5[4], c: sum9[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            // borrows from bit 4 and bit 8, incoming carry only for sbc
            cin      = (op == OP_SBC) ? f_in.c : 1'b0;
            diff     = a - b - {7'b0, cin};
            o.flags  = '{z: (diff == 8'h00), n: 1'b1,
                         h: ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'b0, cin})),
                         c: ({1'b0, a} < ({1'b0, b} + {8'b0, cin}))};
            o.result = {8'h00, (op == OP_CP) ? a : diff};
         end
         OP_AND: begin
            o.result = {8'h00, a & b};
            o.flags  = '{z: ((a & b) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         OP_XOR: begin
            o.result = {8'h00, a ^ b};
            o.flags  = '{z: ((a ^ b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_OR: begin
            o.result = {8'h00, a | b};
            o.flags  = '{z: ((a | b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_INC: begin
            o.result = {8'h00, a + 8'h01};
            o.flags  = '{z: (a == 8'hFF), n: 1'b0, h: (a[3:0] == 4'hF), c: f_in.c};
         end
         OP_DEC: begin
            o.result = {8'h00, a - 8'h01};
            o.flags  = '{z: (a == 8'h01), n: 1'b1, h: (a[3:0] == 4'h0), c: f_in.c};
         end
         OP_ADD16: begin
            // zero flag is kept
            sum13    = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
            sum17    = {1'b0, a16} + {1'b0, b16};
            o.result = sum17[15:0];
            o.flags  = '{z: f_in.z, n: 1'b0, h: sum13[12], c: sum17[16]};
         end
         default: begin
            o.result = '0;
            o.flags  = f_in;
         end
      endcase
      return o;
   endfunction

   function automatic dir_row_type row(input logic [3:0] op, input logic [WORD_W-1:0] a,
                                       input logic [WORD_W-1:0] b, input bit typed,
                                       input logic [WORD_W-1:0] res, input logic [3:0] fl);
      dir_row_type r;
      r.op    = op;
      r.a     = a;
      r.b     = b;
      r.typed = typed;
      r.exp   = alu_out_type'({res, fl});
      return r;
   endfunction

   // Operand biased toward the byte and nibble edges that move the flags
   function automatic logic [WORD_W-1:0] rand_operand();
      logic [WORD_W-1:0] v;
      v = WORD_W'($urandom);
      case ($urandom_range(0, 7))
         0: v[7:0] = 8'hFF;
         1: v[7:0] = 8'h00;
         2: v[3:0] = 4'hF;
         3: v[3:0] = 4'h0;
         4: v[11:0] = 12'hFFF;
         default: ;
      endcase
      return v;
   endfunction

   // Offer one request transaction and record its prediction once accepted
   task automatic offer(input logic [3:0] op, input logic [WORD_W-1:0] a,
                        input logic [WORD_W-1:0] b, input bit typed, input alu_out_type exp,
                        input int gap);
      alu_out_type predicted;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, b, a, op};
      do @(posedge clock); while (!req_tready);
      predicted    = alu_eval(op, a, b, flags_shadow);
      flags_shadow = predicted.flags;
      pending_results.push_back(typed ? exp : predicted);
   endtask

   // Result side: random stall bursts, one long hold-off on request
   initial begin
      rsp_tready   = 1'b0;
      rx_hold_left = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_left > 0) begin
            rsp_tready   = 1'b0;
            rx_hold_left = rx_hold_left - 1;
         end else if (long_hold_req) begin
            rsp_tready    = 1'b0;
            rx_hold_left  = LONG_HOLD - 1;
            long_hold_req = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_tready   = 1'b0;
            rx_hold_left = $urandom_range(1, 9) - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      alu_out_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: result=%h flags=%b",
                   rsp_tdata[15:0], rsp_tdata[19:16]);
            mismatch_count++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_tdata[15:0] !== exp.result) begin
               $error("result: expected %h, actual %h", exp.result, rsp_tdata[15:0]);
               mismatch_count++;
            end
            if (rsp_tdata[19:16] !== exp.flags) begin
               $error("flags_out: expected %b, actual %b", exp.flags, rsp_tdata[19:16]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      logic [3:0]        op;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      int                gap;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      flags_shadow   = '0;
      mismatch_count = 0;
      idle_cycles    = 0;
      long_hold_req  = 1'b0;
      quiet_tail     = 1'b0;

      // directed rows; expected flags are written ZNHC
      dir_rows.push_back(row(OP_XOR,   16'hFFFF, 16'hFFFF, 1, 16'h0000, 4'b1000));
      dir_rows.push_back(row(OP_ADD,   16'h00FF, 16'h0001, 1, 16'h0000, 4'b1011));
      dir_rows.push_back(row(OP_ADD,   16'hFFFF, 16'hFFFF, 1, 16'h00FE, 4'b0011));
      dir_rows.push_back(row(OP_ADC,   16'h000F, 16'h0000, 0, '0, '0));
      dir_rows.push_back(row(OP_ADC,   16'h00FF, 16'h00FF, 0, '0, '0));
      dir_rows.push_back(row(OP_ADC,   16'h0000, 16'h00FF, 0, '0, '0));
      dir_rows.push_back(row(OP_SUB,   16'h0000, 16'h0001, 1, 16'h00FF, 4'b0111));
      dir_rows.push_back(row(OP_SBC,   16'h0010, 16'h0000, 0, '0, '0));
      dir_rows.push_back(row(OP_SBC,   16'h00FF, 16'h00FF, 0, '0, '0));
      dir_rows.push_back(row(OP_SUB,   16'h0080, 16'h0080, 1, 16'h0000, 4'b1100));
      dir_rows.push_back(row(OP_SBC,   16'hFFFF, 16'h0000, 0, '0, '0));
      dir_rows.push_back(row(OP_AND,   16'hFFFF, 16'h0000, 1, 16'h0000, 4'b1010));
      dir_rows.push_back(row(OP_AND,   16'h00FF, 16'h00FF, 1, 16'h00FF, 4'b0010));
      dir_rows.push_back(row(OP_OR,    16'h0000, 16'h0000, 1, 16'h0000, 4'b1000));
      dir_rows.push_back(row(OP_OR,    16'h00F0, 16'h000F, 1, 16'h00FF, 4'b0000));
      dir_rows.push_back(row(OP_XOR,   16'h00AA, 16'h0055, 1, 16'h00FF, 4'b0000));
      dir_rows.push_back(row(OP_CP,    16'h0042, 16'h0042, 1, 16'h0042, 4'b1100));
      dir_rows.push_back(row(OP_CP,    16'h0000, 16'h00FF, 1, 16'h0000, 4'b0111));
      dir_rows.push_back(row(OP_INC,   16'h00FF, 16'hFFFF, 0, '0, '0));
      dir_rows.push_back(row(OP_INC,   16'h000E, 16'h0000, 0, '0, '0));
      dir_rows.push_back(row(OP_DEC,   16'h0000, 16'hFFFF, 0, '0, '0));
      dir_rows.push_back(row(OP_DEC,   16'h0001, 16'h0000, 0, '0, '0));
      dir_rows.push_back(row(OP_ADD16, 16'hFFFF, 16'h0001, 0, '0, '0));
      dir_rows.push_back(row(OP_ADD16, 16'h0FFF, 16'h0001, 0, '0, '0));
      dir_rows.push_back(row(OP_ADD16, 16'h8000, 16'h8000, 0, '0, '0));
      dir_rows.push_back(row(OP_RSVD_LO, 16'hFFFF, 16'hFFFF, 0, '0, '0));
      dir_rows.push_back(row(OP_RSVD_HI, 16'h0000, 16'h0000, 0, '0, '0));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
         offer(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
               dir_rows[i].exp, gap);
      end

      // random operations, mostly defined opcodes
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == HOLD_AT) long_hold_req = 1'b1;
         if (i == RAND_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
         if (i == PAUSE_AT) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         if ($urandom_range(0, 9) < 9) begin
            op = 4'($urandom_range(OP_ADD, OP_ADD16));
         end else begin
            op = 4'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
         end
         a = rand_operand();
         b = ($urandom_range(0, 9) == 0) ? a : rand_operand();
         // keep offering while the result side is held off
         if (quiet_tail || long_hold_req || rx_hold_left > 9 || $urandom_range(0, 4) != 0) begin
            gap = 0;
         end else begin
            gap = $urandom_range(1, 9);
         end
         offer(op, a, b, 1'b0, '0, gap);
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/calu_pkg.sv
src/calu_core.sv
src/cpu_alu_with_flags_unit.sv
tb/sv/cpu_alu_with_flags_unit_test.sv
